// ===== rtl/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// pose frame receiver.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam logic [1:0]  STATUS_OK      = 2'd0;
    localparam logic [1:0]  STATUS_INVALID = 2'd1;
    localparam logic [1:0]  STATUS_CRC     = 2'd2;

    localparam logic [0:0]  REQ_BYTE       = 1'b0;
    localparam logic [0:0]  REQ_LINK_ERR   = 1'b1;

    localparam logic [1:0]  REG_START_FIRST  = 2'd0;
    localparam logic [1:0]  REG_START_SECOND = 2'd1;
    localparam logic [1:0]  REG_VERSION      = 2'd2;
    localparam logic [1:0]  REG_MSG_TYPE     = 2'd3;

    localparam int          FRAME_LEN      = 23;
    localparam logic [7:0]  PAYLOAD_LEN    = 8'd14;
    localparam logic [8:0]  HEADER_EXTRA   = 9'd9;
    localparam logic [8:0]  CRC_FIRST_POS  = 9'd2;
    localparam logic [8:0]  CRC_LAST_POS   = 9'd20;
    localparam logic [8:0]  LEN_BYTE_NEXT  = 9'd5;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;

    typedef struct packed {
        logic [7:0] start_first;
        logic [7:0] start_second;
        logic [7:0] version;
        logic [7:0] msg_type;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        sequence_res;
        logic signed [31:0] x_mm;
        logic signed [31:0] y_mm;
        logic signed [15:0] heading;
        logic signed [15:0] lin_speed;
        logic signed [15:0] turn_rate;
        logic [31:0]        valid_frames;
        logic [31:0]        invalid_frames;
        logic [31:0]        crc_errors;
        logic [31:0]        bytes_seen;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/pfr_parser.sv =====
// ----------------------------------------------------------------------------
// pfr_parser
// Frame parser state: hunt, frame byte store, running CRC, counters, and the
// per-beat decode of a finished frame.
// ----------------------------------------------------------------------------
module pfr_parser #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             req_type,
    input  logic [7:0]       rx_byte,
    input  pfr_pkg::cfg_t    cfg,
    output logic             res_valid,
    output pfr_pkg::result_t res
);

    localparam logic [8:0] MaxLen = 9'(MAX_FRAME_BYTES);
    localparam logic [8:0] FrameLen = 9'(pfr_pkg::FRAME_LEN);

    logic [7:0]  frame_reg [pfr_pkg::FRAME_LEN];
    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  exp_reg, exp_next;
    logic [15:0] crc_reg, crc_next;
    logic [31:0] valid_cnt_reg, valid_cnt_next;
    logic [31:0] invalid_cnt_reg, invalid_cnt_next;
    logic [31:0] crc_cnt_reg, crc_cnt_next;
    logic [31:0] byte_cnt_reg, byte_cnt_next;

    logic        frame_we;
    logic [4:0]  frame_idx;
    logic [8:0]  pos_inc;
    logic [8:0]  len_calc;
    logic        hdr_bad;
    logic        crc_bad;
    logic        finish;

    assign pos_inc   = pos_reg + 9'd1;
    assign len_calc  = {1'b0, rx_byte} + pfr_pkg::HEADER_EXTRA;
    assign frame_idx = pos_reg[4:0];

    assign hdr_bad = (frame_reg[0] != cfg.start_first) ||
                     (frame_reg[1] != cfg.start_second) ||
                     (frame_reg[2] != cfg.version) ||
                     (frame_reg[3] != cfg.msg_type) ||
                     (frame_reg[4] != pfr_pkg::PAYLOAD_LEN);
    // byte 22 (CRC high) is the current beat
    assign crc_bad = crc_reg != {rx_byte, frame_reg[21]};

    always_comb
    begin
        pos_next         = pos_reg;
        exp_next         = exp_reg;
        crc_next         = crc_reg;
        valid_cnt_next   = valid_cnt_reg;
        invalid_cnt_next = invalid_cnt_reg;
        crc_cnt_next     = crc_cnt_reg;
        byte_cnt_next    = byte_cnt_reg;
        frame_we         = 1'b0;
        finish           = 1'b0;
        res_valid        = 1'b0;
        res              = '0;
        res.status       = pfr_pkg::STATUS_INVALID;

        if (req_type == pfr_pkg::REQ_LINK_ERR)
        begin
            pos_next         = '0;
            exp_next         = '0;
            crc_next         = pfr_pkg::CRC_INIT;
            invalid_cnt_next = invalid_cnt_reg + 32'd1;
            res_valid        = 1'b1;
        end
        else
        begin
            byte_cnt_next = byte_cnt_reg + 32'd1;
            if (pos_reg == 9'd0)
            begin
                if (rx_byte == cfg.start_first)
                begin
                    frame_we = 1'b1;
                    pos_next = 9'd1;
                end
            end
            else if (pos_reg == 9'd1)
            begin
                if (rx_byte == cfg.start_second)
                begin
                    frame_we = 1'b1;
                    pos_next = 9'd2;
                end
                else if (rx_byte != cfg.start_first)
                begin
                    pos_next = '0;
                    exp_next = '0;
                    crc_next = pfr_pkg::CRC_INIT;
                end
            end
            else
            begin
                frame_we = pos_reg < FrameLen;
                if (pos_reg >= pfr_pkg::CRC_FIRST_POS && pos_reg <= pfr_pkg::CRC_LAST_POS)
                begin
                    crc_next = pfr_pkg::crc_byte(crc_reg, rx_byte);
                end
                pos_next = pos_inc;
                if (pos_inc == pfr_pkg::LEN_BYTE_NEXT)
                begin
                    exp_next = len_calc;
                    if (len_calc > MaxLen)
                    begin
                        invalid_cnt_next = invalid_cnt_reg + 32'd1;
                        pos_next         = '0;
                        exp_next         = '0;
                        crc_next         = pfr_pkg::CRC_INIT;
                        res_valid        = 1'b1;
                    end
                end
                else if (exp_reg != 9'd0 && pos_inc == exp_reg)
                begin
                    finish = 1'b1;
                end
            end
        end

        if (finish)
        begin
            res_valid = 1'b1;
            pos_next  = '0;
            exp_next  = '0;
            crc_next  = pfr_pkg::CRC_INIT;
            if (exp_reg != FrameLen)
            begin
                invalid_cnt_next = invalid_cnt_reg + 32'd1;
            end
            else if (hdr_bad || crc_bad)
            begin
                invalid_cnt_next = invalid_cnt_reg + 32'd1;
                if (crc_bad)
                begin
                    crc_cnt_next = crc_cnt_reg + 32'd1;
                    res.status   = pfr_pkg::STATUS_CRC;
                end
            end
            else
            begin
                valid_cnt_next     = valid_cnt_reg + 32'd1;
                res.status         = pfr_pkg::STATUS_OK;
                res.sequence_res   = {frame_reg[6], frame_reg[5]};
                res.x_mm           = {frame_reg[10], frame_reg[9], frame_reg[8], frame_reg[7]};
                res.y_mm           = {frame_reg[14], frame_reg[13], frame_reg[12], frame_reg[11]};
                res.heading        = {frame_reg[16], frame_reg[15]};
                res.lin_speed      = {frame_reg[18], frame_reg[17]};
                res.turn_rate      = {frame_reg[20], frame_reg[19]};
            end
        end

        res.valid_frames   = valid_cnt_next;
        res.invalid_frames = invalid_cnt_next;
        res.crc_errors     = crc_cnt_next;
        res.bytes_seen     = byte_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            exp_reg         <= '0;
            crc_reg         <= pfr_pkg::CRC_INIT;
            valid_cnt_reg   <= '0;
            invalid_cnt_reg <= '0;
            crc_cnt_reg     <= '0;
            byte_cnt_reg    <= '0;
        end
        else if (step)
        begin
            pos_reg         <= pos_next;
            exp_reg         <= exp_next;
            crc_reg         <= crc_next;
            valid_cnt_reg   <= valid_cnt_next;
            invalid_cnt_reg <= invalid_cnt_next;
            crc_cnt_reg     <= crc_cnt_next;
            byte_cnt_reg    <= byte_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && frame_we)
        begin
            frame_reg[frame_idx] <= rx_byte;
        end
    end

endmodule

// ===== rtl/pose_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// pose_frame_receiver
// Receives link bytes and link-error events, parses pose/velocity frames
// and emits decoded fields with status and running counters.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat is a received byte
// (req_type 0) or a link-error event (req_type 1).
// Output channel (out_valid/out_ready): one beat at a frame end, on an
// oversize length byte or on a link error; other bytes produce none.
// The APB port holds the start bytes, version and message type; write it
// only while the block is idle.
// With no stall, a beat accepted into the input stage is decoded in the next
// cycle and its result is registered in the output register that drives
// out_valid; the result is taken while out_ready is high.
// Throughput: one beat per cycle when not stalled; CRC update, frame checks
// and field decode are combinational from input stage to result register.
// Reset: parser back to hunting, CRC to 0xFFFF, all counters cleared,
// configuration registers to their default values.
// Stall: when out_ready is low and a result waits, the input stage holds
// one more beat and then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module pose_frame_receiver #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [7:0]         rx_byte,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [15:0]        sequence_res,
    output logic signed [31:0] x_mm,
    output logic signed [31:0] y_mm,
    output logic signed [15:0] heading,
    output logic signed [15:0] lin_speed,
    output logic signed [15:0] turn_rate,
    output logic [31:0]        valid_frames,
    output logic [31:0]        invalid_frames,
    output logic [31:0]        crc_errors,
    output logic [31:0]        bytes_seen
);

    pfr_pkg::cfg_t    cfg_reg;
    logic             s1_valid_reg;
    logic             s1_req_reg;
    logic [7:0]       s1_byte_reg;
    logic             out_valid_reg;
    pfr_pkg::result_t out_reg;
    logic             adv;
    logic             res_valid;
    pfr_pkg::result_t res;
    logic [1:0]       reg_sel;

    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (reg_sel)
            pfr_pkg::REG_START_FIRST:  prdata = {24'd0, cfg_reg.start_first};
            pfr_pkg::REG_START_SECOND: prdata = {24'd0, cfg_reg.start_second};
            pfr_pkg::REG_VERSION:      prdata = {24'd0, cfg_reg.version};
            pfr_pkg::REG_MSG_TYPE:     prdata = {24'd0, cfg_reg.msg_type};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_first  <= 8'd170;
            cfg_reg.start_second <= 8'd85;
            cfg_reg.version      <= 8'd1;
            cfg_reg.msg_type     <= 8'd1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                pfr_pkg::REG_START_FIRST:  cfg_reg.start_first  <= pwdata[7:0];
                pfr_pkg::REG_START_SECOND: cfg_reg.start_second <= pwdata[7:0];
                pfr_pkg::REG_VERSION:      cfg_reg.version      <= pwdata[7:0];
                pfr_pkg::REG_MSG_TYPE:     cfg_reg.msg_type     <= pwdata[7:0];
                default:                   cfg_reg.msg_type     <= cfg_reg.msg_type;
            endcase
        end
    end

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_req_reg  <= req_type;
            s1_byte_reg <= rx_byte;
        end
        if (adv && s1_valid_reg && res_valid)
        begin
            out_reg <= res;
        end
    end

    pfr_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_valid_reg && adv),
        .req_type  (s1_req_reg),
        .rx_byte   (s1_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign sequence_res   = out_reg.sequence_res;
    assign x_mm           = out_reg.x_mm;
    assign y_mm           = out_reg.y_mm;
    assign heading        = out_reg.heading;
    assign lin_speed      = out_reg.lin_speed;
    assign turn_rate      = out_reg.turn_rate;
    assign valid_frames   = out_reg.valid_frames;
    assign invalid_frames = out_reg.invalid_frames;
    assign crc_errors     = out_reg.crc_errors;
    assign bytes_seen     = out_reg.bytes_seen;

endmodule
